>>> rtl/mmsf_pkg.sv
// Shared types, constants and weight tables of the multi-mode smoothing filter.
package mmsf_pkg;

	localparam int SAMPLE_WIDTH = 32;
	localparam int FRAC_BITS    = 16;
	localparam int MAX_WINDOW   = 15;
	localparam int TAPS         = ((MAX_WINDOW - 1) | 1);
	localparam int CENTER       = (TAPS - 1) / 2;
	localparam int HALF_W       = 3;
	localparam int K_W          = 4;
	localparam int IDX_W        = 4;
	localparam int ALPHA_W      = 17;
	localparam int WEIGHT_W     = FRAC_BITS + 1;
	localparam int EMA_W        = ALPHA_W + SAMPLE_WIDTH + 2;
	localparam int PROD_W       = SAMPLE_WIDTH + WEIGHT_W + 1;
	localparam int GROUPS       = (TAPS + 3) / 4;
	localparam int PART_W       = PROD_W + 2;
	localparam int ACC_W        = PROD_W + 4;
	localparam int NB_W         = 39;
	localparam int NL_W         = 21;
	localparam int NH_W         = NB_W - NL_W;
	localparam int RECIP_W      = 33;
	localparam int RECIP_SHIFT  = 35;
	localparam int PH_W         = NH_W + RECIP_W;
	localparam int QH_W         = PH_W - RECIP_SHIFT;
	localparam int DEN_W        = 8;
	localparam int REM_W        = 7;
	localparam int XL_W         = REM_W + NL_W;
	localparam int PL_W         = XL_W + RECIP_W;
	localparam int QL_W         = PL_W - RECIP_SHIFT;
	localparam int QF_W         = QH_W + NL_W;
	localparam int ADDR_W       = 4;
	localparam int DATA_W       = 32;

	localparam logic [FRAC_BITS-1:0] ROUND = FRAC_BITS'(1) << (FRAC_BITS - 1);

	localparam logic [1:0] MODE_EXP   = 2'd0;
	localparam logic [1:0] MODE_GAUSS = 2'd1;
	localparam logic [1:0] MODE_TRI   = 2'd2;
	localparam logic [1:0] MODE_SG    = 2'd3;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WINDOW = 2'd1;
	localparam logic [1:0] REG_ALPHA  = 2'd2;

	localparam logic [3:0]         WINDOW_RESET = 4'd5;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 17'd19661;
	localparam logic [ALPHA_W-1:0] ALPHA_MIN    = 17'd655;
	localparam logic [ALPHA_W-1:0] ALPHA_MAX    = 17'd65536;

	typedef enum logic [1:0] {KIND_EMA, KIND_GAUSS, KIND_TRI} job_kind_t;
	typedef enum logic {SEQ_FIRST, SEQ_FLUSH} seq_state_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           last_in;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] smoothed;
		logic                           last_out;
	} out_item_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [HALF_W-1:0]  half;
		logic [ALPHA_W-1:0] alpha;
	} cfg_t;

	typedef struct packed {
		logic [TAPS-1:0][SAMPLE_WIDTH-1:0] hist;
		logic [SAMPLE_WIDTH-1:0]           ema;
		job_kind_t                         kind;
		logic [HALF_W-1:0]                 half;
		logic [K_W-1:0]                    k;
		logic [HALF_W-1:0]                 rstart;
		logic                              flush;
		logic                              last;
	} job_t;

	typedef struct packed {
		job_kind_t               kind;
		logic                    last_out;
		logic [HALF_W-1:0]       half;
		logic [SAMPLE_WIDTH-1:0] value;
	} ctl_t;

	localparam logic [WEIGHT_W-1:0] GAUSS_ROM [0:7][0:7] = '{
		'{17'd65536, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0},
		'{17'd51576, 17'd6980, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0},
		'{17'd26386, 17'd16004, 17'd3571, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0},
		'{17'd17738, 17'd14205, 17'd7293, 17'd2401, 17'd0, 17'd0, 17'd0, 17'd0},
		'{17'd13380, 17'd11808, 17'd8115, 17'd4344, 17'd1811, 17'd0, 17'd0, 17'd0},
		'{17'd10744, 17'd9920, 17'd7803, 17'd5231, 17'd2988, 17'd1454, 17'd0, 17'd0},
		'{17'd8978, 17'd8495, 17'd7191, 17'd5447, 17'd3692, 17'd2239, 17'd1215, 17'd0},
		'{17'd7714, 17'd7405, 17'd6551, 17'd5342, 17'd4014, 17'd2780, 17'd1775, 17'd1044}
	};

	function automatic logic [WEIGHT_W-1:0] gauss_weight(input logic [HALF_W-1:0] h,
		input logic [HALF_W-1:0] a);
		return GAUSS_ROM[h][a];
	endfunction

	// Triangular divisor 2*(half+1)^2.
	function automatic logic [DEN_W-1:0] tri_den(input logic [HALF_W-1:0] h);
		logic [DEN_W-1:0] hp;
		hp = DEN_W'(h) + 1'b1;
		return (hp * hp) << 1;
	endfunction

	// ceil(2^35 / tri_den(h)): exact floor quotient for dividends below 2^28.
	function automatic logic [RECIP_W-1:0] tri_recip(input logic [HALF_W-1:0] h);
		logic [RECIP_W-1:0] m;
		case (h)
			3'd1:    m = 33'd4294967296;
			3'd2:    m = 33'd1908874354;
			3'd3:    m = 33'd1073741824;
			3'd4:    m = 33'd687194768;
			3'd5:    m = 33'd477218589;
			3'd6:    m = 33'd350609576;
			3'd7:    m = 33'd268435456;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

>>> rtl/mmsf_front.sv
// Front part: accepts samples, keeps history and running average, builds jobs.
module mmsf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  mmsf_pkg::in_item_t sample_data,
	input  mmsf_pkg::cfg_t    cfg,
	output logic              push,
	output mmsf_pkg::job_t    push_job,
	input  logic              full
);
	import mmsf_pkg::*;

	logic [TAPS-1:0][SAMPLE_WIDTH-1:0] hist_q;
	logic [TAPS-1:0][SAMPLE_WIDTH-1:0] hist_next;
	logic [SAMPLE_WIDTH-1:0]           ema_q;
	logic [SAMPLE_WIDTH-1:0]           ema_next;
	logic [K_W-1:0]                    fill_q;
	logic                              in_seq_q;
	logic                              accept;
	logic                              windowed;
	logic                              last;
	logic [K_W-1:0]                    k;
	logic signed [SAMPLE_WIDTH:0]      diff;
	logic signed [EMA_W-1:0]           prod;
	logic [EMA_W-1:0]                  rounded;
	job_kind_t                         kind;

	assign sample_ready = !full;
	assign accept       = sample_valid && sample_ready;
	assign last         = sample_data.last_in;
	assign k            = in_seq_q ? fill_q : '0;
	assign windowed     = cfg.mode != MODE_EXP;

	// prev + alpha*(x - prev), rounded: same as the blended form, one multiplier
	assign diff    = $signed({sample_data.sample[SAMPLE_WIDTH-1], sample_data.sample})
		- $signed({ema_q[SAMPLE_WIDTH-1], ema_q});
	assign prod    = $signed({1'b0, cfg.alpha}) * diff;
	assign rounded = prod + EMA_W'(ROUND);
	assign ema_next = in_seq_q ? ema_q + rounded[FRAC_BITS +: SAMPLE_WIDTH]
		: sample_data.sample;

	assign hist_next = {hist_q[TAPS-2:0], sample_data.sample};

	always_comb begin
		case (cfg.mode)
			MODE_EXP: kind = KIND_EMA;
			MODE_TRI: kind = KIND_TRI;
			default:  kind = KIND_GAUSS;
		endcase
	end

	always_comb begin
		push_job.hist  = hist_next;
		push_job.ema   = ema_next;
		push_job.kind  = kind;
		push_job.half  = cfg.half;
		push_job.k     = k;
		push_job.flush = last && windowed;
		push_job.last  = last;
		if (last && (k < K_W'(cfg.half))) begin
			push_job.rstart = k[HALF_W-1:0];
		end else begin
			push_job.rstart = cfg.half;
		end
	end

	// Drop items that produce no result (window still filling).
	assign push = accept && (!windowed || last || (k >= K_W'(cfg.half)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			in_seq_q <= 1'b0;
		end else if (accept) begin
			in_seq_q <= !last;
			if (last) begin
				fill_q <= '0;
			end else if (k == K_W'(MAX_WINDOW)) begin
				fill_q <= k;
			end else begin
				fill_q <= k + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hist_q <= hist_next;
			ema_q  <= ema_next;
		end
	end

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_seq_q |-> fill_q == '0)
		else $error("fill count set outside a sequence");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> !in_seq_q)
		else $error("sequence not closed by last sample");

endmodule

>>> rtl/mmsf_queue.sv
// Two-entry job queue between the front and back parts.
module mmsf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mmsf_pkg::job_t push_job,
	output logic           full,
	output logic           head_valid,
	output mmsf_pkg::job_t head_job,
	input  logic           pop
);
	import mmsf_pkg::*;

	job_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full       = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head_job   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule

>>> rtl/mmsf_back.sv
// Back part: walks each job's result centres and runs the weighted-sum pipeline.
module mmsf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  mmsf_pkg::job_t      head_job,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_ready,
	output mmsf_pkg::out_item_t result
);
	import mmsf_pkg::*;

	seq_state_t        state_q;
	seq_state_t        state_next;
	logic [HALF_W-1:0] r_q;
	logic [HALF_W-1:0] cur_r;
	logic              en;
	logic              issue;
	logic              done;
	logic              issue_last;

	logic [TAPS-1:0][SAMPLE_WIDTH-1:0] tap_sel;
	logic [TAPS-1:0][WEIGHT_W-1:0]     wt_sel;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8;

	logic [TAPS-1:0][SAMPLE_WIDTH-1:0] tap_s1;
	logic [TAPS-1:0][WEIGHT_W-1:0]     wt_s1;
	logic signed [PROD_W-1:0]          prod_s2 [TAPS];
	logic signed [PART_W-1:0]          part_sum [GROUPS];
	logic signed [PART_W-1:0]          part_s3 [GROUPS];
	logic signed [ACC_W-1:0]           acc_sum;
	logic signed [ACC_W-1:0]           acc_s4;
	logic [ACC_W+1:0]                  nb_full;
	logic [ACC_W-1:0]                  gsum;
	logic [DEN_W-1:0]                  den_s4;
	logic [NB_W-1:0]                   nb_s5;
	logic [PH_W-1:0]                   ph_s6;
	logic [NH_W-1:0]                   nh_s6;
	logic [NL_W-1:0]                   nl_s6;
	logic [QH_W-1:0]                   qh;
	logic [NH_W-1:0]                   qd;
	logic [NH_W-1:0]                   rh;
	logic [QH_W-1:0]                   qh_s7;
	logic [XL_W-1:0]                   x_s7;
	logic [QH_W-1:0]                   qh_s8;
	logic [PL_W-1:0]                   pl_s8;
	logic [QF_W-1:0]                   qfull;
	out_item_t                         result_s9;

	// Whole pipeline advances together; stall only when the output is held.
	assign en    = !v_s9 || result_ready;
	assign cur_r = (state_q == SEQ_FLUSH) ? r_q : head_job.rstart;
	assign issue = en && head_valid;
	assign done  = !head_job.flush || (cur_r == '0);
	assign pop   = issue && done;

	always_comb begin
		case (state_q)
			SEQ_FIRST: state_next = (issue && !done) ? SEQ_FLUSH : SEQ_FIRST;
			SEQ_FLUSH: state_next = (issue && done) ? SEQ_FIRST : SEQ_FLUSH;
			default:   state_next = SEQ_FIRST;
		endcase
	end

	always_comb begin
		if (head_job.flush) begin
			issue_last = cur_r == '0;
		end else begin
			issue_last = (head_job.kind == KIND_EMA) && head_job.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_FIRST;
			r_q     <= '0;
		end else begin
			state_q <= state_next;
			if (issue && !done) begin
				r_q <= cur_r - 1'b1;
			end
		end
	end

	// Tap selection: clamp each tap to the samples of this sequence.
	always_comb begin
		int t;
		int jv;
		int aj;
		int off;
		int lim;
		lim = (int'(head_job.k) > TAPS - 1) ? TAPS - 1 : int'(head_job.k);
		for (t = 0; t < TAPS; t++) begin
			jv = t - CENTER;
			aj = (jv < 0) ? -jv : jv;
			off = int'(cur_r) - jv;
			if (off < 0) begin
				off = 0;
			end
			if (off > lim) begin
				off = lim;
			end
			tap_sel[t] = head_job.hist[IDX_W'(off)];
			if (head_job.kind == KIND_TRI) begin
				wt_sel[t] = (aj <= int'(head_job.half))
					? WEIGHT_W'(int'(head_job.half) + 1 - aj) : '0;
			end else begin
				wt_sel[t] = gauss_weight(head_job.half, HALF_W'(aj));
			end
		end
	end

	always_comb begin
		int g;
		int i;
		for (g = 0; g < GROUPS; g++) begin
			part_sum[g] = '0;
			for (i = 0; i < 4; i++) begin
				if (4 * g + i < TAPS) begin
					part_sum[g] = part_sum[g] + PART_W'(prod_s2[4 * g + i]);
				end
			end
		end
	end

	always_comb begin
		int g;
		acc_sum = '0;
		for (g = 0; g < GROUPS; g++) begin
			acc_sum = acc_sum + ACC_W'(part_s3[g]);
		end
	end

	assign den_s4  = tri_den(ctl_s4.half);
	assign gsum    = acc_s4 + ACC_W'(ROUND);
	// 2*acc + den/2, biased by den*2^31 so the dividend is never negative.
	assign nb_full = {acc_s4[ACC_W-1], acc_s4, 1'b0} + (ACC_W+2)'(den_s4 >> 1)
		+ ((ACC_W+2)'(den_s4) << (SAMPLE_WIDTH - 1));

	assign qh    = ph_s6[RECIP_SHIFT +: QH_W];
	assign qd    = NH_W'(qh) * NH_W'(tri_den(ctl_s6.half));
	assign rh    = nh_s6 - qd;
	assign qfull = {qh_s8, NL_W'(0)} + QF_W'(pl_s8[RECIP_SHIFT +: QL_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <=
				{issue, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s1          <= tap_sel;
			wt_s1           <= wt_sel;
			ctl_s1.kind     <= head_job.kind;
			ctl_s1.last_out <= issue_last;
			ctl_s1.half     <= head_job.half;
			ctl_s1.value    <= head_job.ema;

			for (int t = 0; t < TAPS; t++) begin
				prod_s2[t] <= $signed(tap_s1[t]) * $signed({1'b0, wt_s1[t]});
			end
			ctl_s2 <= ctl_s1;

			part_s3 <= part_sum;
			ctl_s3  <= ctl_s2;

			acc_s4 <= acc_sum;
			ctl_s4 <= ctl_s3;

			nb_s5           <= nb_full[NB_W-1:0];
			ctl_s5.kind     <= ctl_s4.kind;
			ctl_s5.last_out <= ctl_s4.last_out;
			ctl_s5.half     <= ctl_s4.half;
			ctl_s5.value    <= (ctl_s4.kind != KIND_EMA)
				? gsum[FRAC_BITS +: SAMPLE_WIDTH] : ctl_s4.value;

			ph_s6  <= nb_s5[NB_W-1:NL_W] * tri_recip(ctl_s5.half);
			nh_s6  <= nb_s5[NB_W-1:NL_W];
			nl_s6  <= nb_s5[NL_W-1:0];
			ctl_s6 <= ctl_s5;

			qh_s7  <= qh;
			x_s7   <= {rh[REM_W-1:0], nl_s6};
			ctl_s7 <= ctl_s6;

			pl_s8  <= x_s7 * tri_recip(ctl_s7.half);
			qh_s8  <= qh_s7;
			ctl_s8 <= ctl_s7;

			// Remove the bias again: flip the sign bit of the 32-bit quotient.
			result_s9.smoothed <= (ctl_s8.kind == KIND_TRI)
				? (qfull[SAMPLE_WIDTH-1:0] ^ {1'b1, (SAMPLE_WIDTH-1)'(0)})
				: ctl_s8.value;
			result_s9.last_out <= ctl_s8.last_out;
		end
	end

	assign result_valid = v_s9;
	assign result       = result_s9;

	a_flush_head: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SEQ_FLUSH |-> head_valid && head_job.flush)
		else $error("flush walk without a flush job at the queue head");
	a_flush_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SEQ_FLUSH |-> r_q < head_job.rstart)
		else $error("flush centre beyond start centre");
	a_pop_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |-> !pop)
		else $error("job retired while pipeline stalled");

endmodule

>>> rtl/multi_mode_smoothing_filter.sv
// Top level of the multi-mode smoothing filter: register port, front, queue, back.
//
//   channel   signals                                   direction  payload
//   sample    sample_valid / sample_ready / sample_data in         sample, last_in
//   result    result_valid / result_ready / result      out        smoothed, last_out
//   config    psel penable pwrite paddr pwdata prdata   in/out     mode, window_size, alpha
//
// One item accepted per cycle while the two-entry job queue has room.
// Each windowed result needs one issue slot in the back part; a last item in
// a windowed mode holds the queue head while it issues centres min(half, fill) down to 0.
// From issue to the output register the back part is a pipeline of 15 parallel tap
// multipliers, an adder tree and reciprocal-multiply division for triangular.
// Asynchronous reset clears handshake and sequence state; no clearing pass.
// An output stall freezes the back pipeline; the front keeps accepting until
// the queue fills.
module multi_mode_smoothing_filter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_ready,
	input  mmsf_pkg::in_item_t               sample_data,
	output logic                             result_valid,
	input  logic                             result_ready,
	output mmsf_pkg::out_item_t              result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mmsf_pkg::ADDR_W-1:0]      paddr,
	input  logic [mmsf_pkg::DATA_W-1:0]      pwdata,
	output logic [mmsf_pkg::DATA_W-1:0]      prdata,
	output logic                             pready
);
	import mmsf_pkg::*;

	logic [1:0]         mode_q;
	logic [3:0]         window_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic               cfg_write;
	logic [1:0]         reg_idx;
	cfg_t               cfg;
	logic               push;
	job_t               push_job;
	logic               full;
	logic               head_valid;
	job_t               head_job;
	logic               pop;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[ADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	// Register writes; addresses past the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_EXP;
			window_q <= WINDOW_RESET;
			alpha_q  <= ALPHA_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_MODE:   mode_q   <= pwdata[1:0];
				REG_WINDOW: window_q <= pwdata[3:0];
				REG_ALPHA:  alpha_q  <= pwdata[ALPHA_W-1:0];
				default:    mode_q   <= mode_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MODE:   prdata = DATA_W'(mode_q);
			REG_WINDOW: prdata = DATA_W'(window_q);
			REG_ALPHA:  prdata = DATA_W'(alpha_q);
			default:    prdata = '0;
		endcase
	end

	// Force the window odd and at least 3; half is then window/2.
	// Clamp alpha to its legal gain range.
	always_comb begin
		cfg.mode = mode_q;
		cfg.half = (window_q[3:1] == '0) ? HALF_W'(1) : window_q[3:1];
		if (alpha_q < ALPHA_MIN) begin
			cfg.alpha = ALPHA_MIN;
		end else if (alpha_q > ALPHA_MAX) begin
			cfg.alpha = ALPHA_MAX;
		end else begin
			cfg.alpha = alpha_q;
		end
	end

	mmsf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_data  (sample_data),
		.cfg          (cfg),
		.push         (push),
		.push_job     (push_job),
		.full         (full)
	);

	mmsf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop)
	);

	mmsf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_job     (head_job),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
